// ===== design/c8lu_pkg.sv =====
// Package for the 8-bit CPU load unit: operation codes, register indexes,
// result codes and the I/O page base. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c8lu_pkg;

    localparam int unsigned NUM_REGS = 7;

    localparam logic [15:0] IO_PAGE = 16'hFF00;

    typedef enum logic [2:0] {
        MODE_REG_REG = 3'd0,
        MODE_REG_IMM = 3'd1,
        MODE_REG_MEM = 3'd2,
        MODE_MEM_REG = 3'd3,
        MODE_MEM_IMM = 3'd4,
        MODE_HL_SPN  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        PTR_HL     = 3'd0,
        PTR_BC     = 3'd1,
        PTR_DE     = 3'd2,
        PTR_IMM16  = 3'd3,
        PTR_IO_C   = 3'd4,
        PTR_IO_IMM = 3'd5,
        PTR_HL_DEC = 3'd6,
        PTR_HL_INC = 3'd7
    } ptr_t;

    typedef enum logic [2:0] {
        REG_A = 3'd0,
        REG_B = 3'd1,
        REG_C = 3'd2,
        REG_D = 3'd3,
        REG_E = 3'd4,
        REG_H = 3'd5,
        REG_L = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_WRITE = 2'd2
    } access_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PENDING = 2'd1,
        ST_REFUSED = 2'd2
    } status_t;

    localparam logic CMD_INSTR  = 1'b0;
    localparam logic CMD_RETURN = 1'b1;

    // Members run from the highest tdata field down, so mode lands in the low bits.
    typedef struct packed {
        logic [15:0] stack_pointer;
        logic [7:0]  read_data;
        logic [15:0] imm_word;
        logic [7:0]  imm_byte;
        logic [2:0]  pointer_mode;
        logic [2:0]  src_reg;
        logic [2:0]  dst_reg;
        logic [2:0]  mode;
    } item_t;

endpackage

`default_nettype wire

// ===== design/cpu_8bit_load_unit.sv =====
// Channel  | dir | tdata (low bit up)                              | tuser
// s_       | in  | mode,dst,src,ptr,imm8,imm16,rdata,sp (60 of 64)  | command
// m_       | out | addr,wdata,value,flags,status (46 of 48)         | access_kind
//
// One beat per cycle in and out while m_ is not stalled; a beat lands in an
// input register, is executed against the register file as it moves on and
// shows in the output register.
// Reset (aresetn low, synchronous) clears registers, flags and pending read.
// A stall on m_ holds the output register; the input register still takes
// a beat while the output waits, then s_tready drops until m_tready returns.
//
// Load/store unit top level; depends on c8lu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpu_8bit_load_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode[2:0], dst_reg[5:3], src_reg[8:6], pointer_mode[11:9], imm_byte[19:12],
    // imm_word[35:20], read_data[43:36], stack_pointer[59:44], zero pad
    input  wire logic [63:0] s_tdata,
    // command[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // access_address[15:0], write_data[23:16], written_value[39:24],
    // flags_value[43:40], status[45:44], zero pad
    output logic [47:0]      m_tdata,
    // access_kind[1:0]
    output logic [1:0]       m_tuser
);

    // Input register.
    logic            in_valid_reg;
    logic            in_cmd_reg;
    c8lu_pkg::item_t in_item_reg;

    // Architectural state.
    logic [7:0] regs_reg [c8lu_pkg::NUM_REGS];
    logic [3:0] flags_reg;
    logic       pend_reg;
    logic [2:0] pend_dst_reg;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [15:0] out_addr_reg;
    logic [7:0]  out_wdata_reg;
    logic [15:0] out_value_reg;
    logic [3:0]  out_flags_reg;
    logic [1:0]  out_status_reg;

    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= s_tuser[0];
            in_item_reg <= c8lu_pkg::item_t'(s_tdata[59:0]);
        end
    end

    // Execute.
    logic [1:0]  res_kind;
    logic [15:0] res_addr;
    logic [7:0]  res_wdata;
    logic [15:0] res_value;
    logic [3:0]  flags_next;
    logic [1:0]  res_status;
    logic        pend_next;
    logic [2:0]  pend_dst_next;
    logic        wr_dst_en;
    logic [2:0]  wr_dst_idx;
    logic [7:0]  wr_dst_data;
    logic        wr_hl_en;
    logic [15:0] wr_hl_data;

    logic [7:0]  src_val;
    logic [15:0] hl_val;
    logic [15:0] ptr_addr;
    logic [15:0] hl_step;
    logic        hl_changes;
    logic [15:0] spn_sum;
    logic [4:0]  half_sum;
    logic [8:0]  low_sum;
    logic        refuse;
    c8lu_pkg::item_t it;

    always_comb begin
        it       = in_item_reg;
        src_val  = (it.src_reg < 3'(c8lu_pkg::NUM_REGS)) ? regs_reg[it.src_reg] : 8'h00;
        hl_val   = {regs_reg[c8lu_pkg::REG_H], regs_reg[c8lu_pkg::REG_L]};
        spn_sum  = it.stack_pointer + {{8{it.imm_byte[7]}}, it.imm_byte};
        half_sum = {1'b0, it.stack_pointer[3:0]} + {1'b0, it.imm_byte[3:0]};
        low_sum  = {1'b0, it.stack_pointer[7:0]} + {1'b0, it.imm_byte};

        hl_changes = 1'b0;
        hl_step    = 16'h0000;
        unique case (it.pointer_mode)
            c8lu_pkg::PTR_HL:     ptr_addr = hl_val;
            c8lu_pkg::PTR_BC:     ptr_addr = {regs_reg[c8lu_pkg::REG_B],
                                              regs_reg[c8lu_pkg::REG_C]};
            c8lu_pkg::PTR_DE:     ptr_addr = {regs_reg[c8lu_pkg::REG_D],
                                              regs_reg[c8lu_pkg::REG_E]};
            c8lu_pkg::PTR_IMM16:  ptr_addr = it.imm_word;
            c8lu_pkg::PTR_IO_C:   ptr_addr = c8lu_pkg::IO_PAGE |
                                             {8'h00, regs_reg[c8lu_pkg::REG_C]};
            c8lu_pkg::PTR_IO_IMM: ptr_addr = c8lu_pkg::IO_PAGE | {8'h00, it.imm_byte};
            c8lu_pkg::PTR_HL_DEC: begin
                ptr_addr   = hl_val;
                hl_step    = hl_val - 16'd1;
                hl_changes = 1'b1;
            end
            c8lu_pkg::PTR_HL_INC: begin
                ptr_addr   = hl_val;
                hl_step    = hl_val + 16'd1;
                hl_changes = 1'b1;
            end
            default: ptr_addr = hl_val;
        endcase

        refuse = pend_reg || (it.mode > c8lu_pkg::MODE_HL_SPN) ||
                 ((it.mode == c8lu_pkg::MODE_REG_REG || it.mode == c8lu_pkg::MODE_REG_IMM ||
                   it.mode == c8lu_pkg::MODE_REG_MEM) &&
                  it.dst_reg >= 3'(c8lu_pkg::NUM_REGS)) ||
                 ((it.mode == c8lu_pkg::MODE_REG_REG || it.mode == c8lu_pkg::MODE_MEM_REG) &&
                  it.src_reg >= 3'(c8lu_pkg::NUM_REGS));

        res_kind      = c8lu_pkg::ACC_NONE;
        res_addr      = 16'h0000;
        res_wdata     = 8'h00;
        res_value     = 16'h0000;
        res_status    = c8lu_pkg::ST_DONE;
        flags_next    = flags_reg;
        pend_next     = pend_reg;
        pend_dst_next = pend_dst_reg;
        wr_dst_en     = 1'b0;
        wr_dst_idx    = it.dst_reg;
        wr_dst_data   = 8'h00;
        wr_hl_en      = 1'b0;
        wr_hl_data    = hl_step;

        if (in_cmd_reg == c8lu_pkg::CMD_RETURN) begin
            if (!pend_reg || pend_dst_reg >= 3'(c8lu_pkg::NUM_REGS)) begin
                res_status = c8lu_pkg::ST_REFUSED;
            end else begin
                wr_dst_en   = 1'b1;
                wr_dst_idx  = pend_dst_reg;
                wr_dst_data = it.read_data;
                pend_next   = 1'b0;
                res_value   = {8'h00, it.read_data};
            end
        end else if (refuse) begin
            res_status = c8lu_pkg::ST_REFUSED;
        end else begin
            unique case (it.mode)
                c8lu_pkg::MODE_REG_REG: begin
                    wr_dst_en   = 1'b1;
                    wr_dst_data = src_val;
                    res_value   = {8'h00, src_val};
                end
                c8lu_pkg::MODE_REG_IMM: begin
                    wr_dst_en   = 1'b1;
                    wr_dst_data = it.imm_byte;
                    res_value   = {8'h00, it.imm_byte};
                end
                c8lu_pkg::MODE_HL_SPN: begin
                    flags_next = {2'b00, half_sum[4], low_sum[8]};
                    wr_hl_en   = 1'b1;
                    wr_hl_data = spn_sum;
                    res_value  = spn_sum;
                end
                c8lu_pkg::MODE_REG_MEM: begin
                    wr_hl_en      = hl_changes;
                    pend_next     = 1'b1;
                    pend_dst_next = it.dst_reg;
                    res_kind      = c8lu_pkg::ACC_READ;
                    res_addr      = ptr_addr;
                    res_value     = hl_changes ? hl_step : 16'h0000;
                    res_status    = c8lu_pkg::ST_PENDING;
                end
                default: begin
                    // Stores: a stored H or L is taken before the pointer update.
                    wr_hl_en  = hl_changes;
                    res_kind  = c8lu_pkg::ACC_WRITE;
                    res_addr  = ptr_addr;
                    res_wdata = (it.mode == c8lu_pkg::MODE_MEM_REG) ? src_val : it.imm_byte;
                    res_value = hl_changes ? hl_step : 16'h0000;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < int'(c8lu_pkg::NUM_REGS); i++) begin
                regs_reg[i] <= 8'h00;
            end
            flags_reg    <= 4'h0;
            pend_reg     <= 1'b0;
            pend_dst_reg <= 3'd0;
        end else if (advance) begin
            if (wr_dst_en) begin
                regs_reg[wr_dst_idx] <= wr_dst_data;
            end
            if (wr_hl_en) begin
                regs_reg[c8lu_pkg::REG_H] <= wr_hl_data[15:8];
                regs_reg[c8lu_pkg::REG_L] <= wr_hl_data[7:0];
            end
            flags_reg    <= flags_next;
            pend_reg     <= pend_next;
            pend_dst_reg <= pend_dst_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_kind_reg   <= res_kind;
            out_addr_reg   <= res_addr;
            out_wdata_reg  <= res_wdata;
            out_value_reg  <= res_value;
            out_flags_reg  <= flags_next;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_status_reg, out_flags_reg, out_value_reg,
                       out_wdata_reg, out_addr_reg};

`ifndef NO_ASSERTIONS
    a_pend_set: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_status == c8lu_pkg::ST_PENDING |=> pend_reg)
        else $error("read issued without pending flag set");

    a_read_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == c8lu_pkg::ACC_READ) ==
                      (m_tdata[45:44] == c8lu_pkg::ST_PENDING)))
        else $error("read access and pending status disagree");

    a_refused_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && pend_reg && in_cmd_reg == c8lu_pkg::CMD_INSTR
        |=> out_status_reg == c8lu_pkg::ST_REFUSED && out_kind_reg == c8lu_pkg::ACC_NONE)
        else $error("instruction accepted while a read was pending");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input refused while input register empty");
`endif

endmodule

`default_nettype wire

// ===== verif/c8lu_track_pkg.sv =====
// Scoreboard for the 8-bit CPU load unit: a cycle-free model of the register file,
// flags and pending read, plus the queue of results still owed by the block.
// Depends on c8lu_pkg.
`timescale 1ns / 1ps

package c8lu_track_pkg;

    import c8lu_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [15:0] value;
        logic [3:0]  flags;
        logic [1:0]  status;
    } lu_result_t;

    class load_unit_tracker;
        logic [7:0]  regs [NUM_REGS];
        logic [3:0]  flags;
        bit          read_busy;
        logic [2:0]  load_dst;
        lu_result_t  awaited_results [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned mode_hits [8];
        int unsigned data_returns;
        int unsigned refusals;

        function new();
            foreach (regs[i]) regs[i] = 8'h00;
            flags = 4'h0;
            read_busy = 1'b0;
            load_dst = 3'd0;
            mismatches = 0;
            results_seen = 0;
            data_returns = 0;
            refusals = 0;
            foreach (mode_hits[i]) mode_hits[i] = 0;
        endfunction

        function logic [15:0] hl();
            return {regs[REG_H], regs[REG_L]};
        endfunction

        function void set_hl(logic [15:0] v);
            regs[REG_H] = v[15:8];
            regs[REG_L] = v[7:0];
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction

        // Runs one accepted input beat through the model and queues what it yields.
        function void note_beat(logic cmd, item_t it);
            lu_result_t r;
            logic [15:0] ptr_addr;
            logic [15:0] hl_next;
            logic [15:0] sum;
            bit          hl_moves;
            bit          bad;
            r = '0;
            r.status = ST_DONE;
            hl_moves = 1'b0;
            hl_next = 16'h0000;
            ptr_addr = 16'h0000;
            if (cmd == CMD_RETURN) begin
                data_returns++;
                if (!read_busy) begin
                    r.status = ST_REFUSED;
                end else begin
                    regs[load_dst] = it.read_data;
                    read_busy = 1'b0;
                    r.value = {8'h00, it.read_data};
                end
            end else begin
                mode_hits[it.mode]++;
                bad = read_busy || (it.mode > MODE_HL_SPN);
                if ((it.mode == MODE_REG_REG || it.mode == MODE_REG_IMM ||
                     it.mode == MODE_REG_MEM) && it.dst_reg >= NUM_REGS)
                    bad = 1'b1;
                if ((it.mode == MODE_REG_REG || it.mode == MODE_MEM_REG) &&
                    it.src_reg >= NUM_REGS)
                    bad = 1'b1;
                if (bad) begin
                    r.status = ST_REFUSED;
                end else begin
                    case (it.mode)
                        MODE_REG_REG: begin
                            regs[it.dst_reg] = regs[it.src_reg];
                            r.value = {8'h00, regs[it.dst_reg]};
                        end
                        MODE_REG_IMM: begin
                            regs[it.dst_reg] = it.imm_byte;
                            r.value = {8'h00, it.imm_byte};
                        end
                        MODE_HL_SPN: begin
                            sum = it.stack_pointer + {{8{it.imm_byte[7]}}, it.imm_byte};
                            flags = 4'h0;
                            flags[1] = ({1'b0, it.stack_pointer[3:0]} +
                                        {1'b0, it.imm_byte[3:0]}) > 5'd15;
                            flags[0] = ({1'b0, it.stack_pointer[7:0]} +
                                        {1'b0, it.imm_byte}) > 9'd255;
                            set_hl(sum);
                            r.value = sum;
                        end
                        default: begin
                            case (it.pointer_mode)
                                PTR_HL:     ptr_addr = hl();
                                PTR_BC:     ptr_addr = {regs[REG_B], regs[REG_C]};
                                PTR_DE:     ptr_addr = {regs[REG_D], regs[REG_E]};
                                PTR_IMM16:  ptr_addr = it.imm_word;
                                PTR_IO_C:   ptr_addr = IO_PAGE + {8'h00, regs[REG_C]};
                                PTR_IO_IMM: ptr_addr = IO_PAGE + {8'h00, it.imm_byte};
                                PTR_HL_DEC: begin
                                    ptr_addr = hl();
                                    hl_next = ptr_addr - 16'd1;
                                    hl_moves = 1'b1;
                                end
                                default: begin
                                    ptr_addr = hl();
                                    hl_next = ptr_addr + 16'd1;
                                    hl_moves = 1'b1;
                                end
                            endcase
                            r.addr = ptr_addr;
                            r.value = hl_moves ? hl_next : 16'h0000;
                            if (it.mode == MODE_REG_MEM) begin
                                read_busy = 1'b1;
                                load_dst = it.dst_reg;
                                r.kind = ACC_READ;
                                r.status = ST_PENDING;
                            end else begin
                                // A stored H or L is taken before the pointer moves.
                                r.wdata = (it.mode == MODE_MEM_REG) ? regs[it.src_reg]
                                                                    : it.imm_byte;
                                r.kind = ACC_WRITE;
                            end
                            if (hl_moves)
                                set_hl(hl_next);
                        end
                    endcase
                end
            end
            if (r.status == ST_REFUSED)
                refusals++;
            r.flags = flags;
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_beat(logic [47:0] data, logic [1:0] user);
            lu_result_t want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual tdata %h tuser %h",
                         $time, data, user);
                return;
            end
            want = awaited_results.pop_front();
            results_seen++;
            compare_field("access_kind", {14'h0, want.kind}, {14'h0, user});
            compare_field("access_address", want.addr, data[15:0]);
            compare_field("write_data", {8'h00, want.wdata}, {8'h00, data[23:16]});
            compare_field("written_value", want.value, data[39:24]);
            compare_field("flags_value", {12'h0, want.flags}, {12'h0, data[43:40]});
            compare_field("status", {14'h0, want.status}, {14'h0, data[45:44]});
            compare_field("tdata pad", 16'h0000, {14'h0, data[47:46]});
        endfunction

        // Anything still queued at the end was never delivered.
        function void close();
            while (awaited_results.size() != 0) begin
                mismatches++;
                $display("%0t: missing result, expected %h, actual none",
                         $time, awaited_results.pop_front());
            end
        endfunction
    endclass

endpackage

// ===== verif/tb_cpu_8bit_load_unit.sv =====
// Testbench top for cpu_8bit_load_unit: directed and random load/store beats with
// random gaps on both channels, checked against load_unit_tracker.
// Depends on c8lu_pkg and c8lu_track_pkg.
`timescale 1ns / 1ps

module tb_cpu_8bit_load_unit;

    import c8lu_pkg::*;
    import c8lu_track_pkg::*;

    localparam int          HALF_PERIOD  = 10;
    localparam int          IDLE_PCT     = 18;
    localparam int          RANDOM_BEATS = 950;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [2:0]  MODE_RSVD_LO = 3'd6;
    localparam logic [2:0]  MODE_RSVD_HI = 3'd7;
    localparam logic [2:0]  REG_NONE     = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    item_t       beat_item = '0;
    bit          steady = 1'b0;
    int unsigned idle_cycles = 0;

    load_unit_tracker lu_model = new();

    cpu_8bit_load_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                lu_model.note_beat(s_tuser[0], beat_item);
            if (m_tvalid && m_tready)
                lu_model.check_beat(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic item_t op(logic [2:0] mode, logic [2:0] dst, logic [2:0] src,
                                 logic [2:0] ptr, logic [7:0] byte_val,
                                 logic [15:0] word_val);
        item_t it;
        it.mode = mode;
        it.dst_reg = dst;
        it.src_reg = src;
        it.pointer_mode = ptr;
        it.imm_byte = byte_val;
        it.imm_word = word_val;
        it.read_data = byte_val;
        it.stack_pointer = word_val;
        return it;
    endfunction

    // Mostly well-formed traffic: a pending read is usually answered, and only a
    // small share of beats carries reserved modes, register 7 or a stray return.
    function automatic void random_beat(bit busy, output logic cmd, output item_t it);
        logic [63:0] raw;
        int unsigned pick;
        raw = {$urandom, $urandom};
        it = raw[59:0];
        pick = $urandom_range(99);
        cmd = CMD_INSTR;
        if (busy) begin
            if (pick < 88)
                cmd = CMD_RETURN;
        end else if (pick < 4) begin
            cmd = CMD_RETURN;
        end else if (pick >= 12) begin
            it.mode = 3'($urandom_range(int'(MODE_HL_SPN)));
            it.dst_reg = 3'($urandom_range(NUM_REGS - 1));
            it.src_reg = 3'($urandom_range(NUM_REGS - 1));
        end
    endfunction

    task automatic send_beat(logic cmd, item_t it);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        beat_item <= it;
        s_tdata <= {4'h0, it.stack_pointer, it.read_data, it.imm_word, it.imm_byte,
                    it.pointer_mode, it.src_reg, it.dst_reg, it.mode};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    initial begin
        logic  cmd;
        item_t it;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill every register with a corner value.
        send_beat(CMD_INSTR, op(MODE_REG_IMM, REG_A, REG_A, PTR_HL, 8'h80, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_REG_IMM, REG_B, REG_A, PTR_HL, 8'h12, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_REG_IMM, REG_C, REG_A, PTR_HL, 8'h34, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_REG_IMM, REG_D, REG_A, PTR_HL, 8'hFF, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_REG_IMM, REG_E, REG_A, PTR_HL, 8'h00, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_REG_IMM, REG_H, REG_A, PTR_HL, 8'hFF, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_REG_IMM, REG_L, REG_A, PTR_HL, 8'hFF, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_REG_REG, REG_A, REG_L, PTR_HL, 8'h00, 16'h0000));
        // Stores through every pointer form but PTR_IO_C, including wrap of HL in both directions.
        send_beat(CMD_INSTR, op(MODE_MEM_REG, REG_A, REG_A, PTR_HL, 8'h00, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_MEM_IMM, REG_A, REG_A, PTR_BC, 8'hFF, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_MEM_REG, REG_A, REG_E, PTR_DE, 8'h00, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_MEM_REG, REG_A, REG_L, PTR_IMM16, 8'h00, 16'hFFFF));
        send_beat(CMD_INSTR, op(MODE_MEM_IMM, REG_A, REG_A, PTR_IO_IMM, 8'hFF, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_MEM_REG, REG_A, REG_L, PTR_HL_INC, 8'h00, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_MEM_REG, REG_A, REG_H, PTR_HL_DEC, 8'h00, 16'h0000));
        // Load into L through HL, an instruction refused while the read waits, the
        // data return, then a return with nothing outstanding.
        send_beat(CMD_INSTR, op(MODE_REG_MEM, REG_L, REG_A, PTR_HL, 8'h00, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_REG_REG, REG_B, REG_A, PTR_HL, 8'h00, 16'h0000));
        send_beat(CMD_RETURN, op(MODE_REG_REG, REG_A, REG_A, PTR_HL, 8'hAA, 16'h0000));
        send_beat(CMD_RETURN, op(MODE_REG_REG, REG_A, REG_A, PTR_HL, 8'h55, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_RSVD_LO, REG_A, REG_A, PTR_HL, 8'h00, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_RSVD_HI, REG_A, REG_A, PTR_HL, 8'h00, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_REG_REG, REG_NONE, REG_A, PTR_HL, 8'h00, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_MEM_REG, REG_A, REG_NONE, PTR_HL, 8'h00, 16'h0000));
        // SP+n: both carries with wrap, a negative offset, half carry alone.
        send_beat(CMD_INSTR, op(MODE_HL_SPN, REG_A, REG_A, PTR_HL, 8'h01, 16'hFFFF));
        send_beat(CMD_INSTR, op(MODE_HL_SPN, REG_A, REG_A, PTR_HL, 8'h80, 16'h0000));
        send_beat(CMD_INSTR, op(MODE_HL_SPN, REG_A, REG_A, PTR_HL, 8'h08, 16'h1238));
        send_beat(CMD_INSTR, op(MODE_REG_MEM, REG_H, REG_A, PTR_HL_DEC, 8'h00, 16'h0000));
        send_beat(CMD_RETURN, op(MODE_REG_REG, REG_A, REG_A, PTR_HL, 8'h00, 16'h0000));

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            steady <= (n >= 300 && n < 450);
            // Hold off once until the block has delivered everything it owes.
            if (n == 650) begin
                s_tvalid <= 1'b0;
                while (lu_model.outstanding() != 0) @(posedge aclk);
                @(negedge aclk);
            end
            random_beat(lu_model.read_busy, cmd, it);
            send_beat(cmd, it);
        end
        s_tvalid <= 1'b0;

        while (lu_model.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        lu_model.close();

        $display("Checked %0d results: %0d reg moves, %0d immediates, %0d loads, %0d stores,",
                 lu_model.results_seen, lu_model.mode_hits[MODE_REG_REG],
                 lu_model.mode_hits[MODE_REG_IMM], lu_model.mode_hits[MODE_REG_MEM],
                 lu_model.mode_hits[MODE_MEM_REG] + lu_model.mode_hits[MODE_MEM_IMM]);
        $display("%0d SP+n, %0d data returns and %0d refused beats; %0d mismatches.",
                 lu_model.mode_hits[MODE_HL_SPN], lu_model.data_returns,
                 lu_model.refusals, lu_model.mismatches);
        if (lu_model.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
